FILE: rtl/lav_pkg.sv
package lav_pkg;

    localparam int RND_W    = 80;
    localparam int NORM_MSB = 30;
    localparam int MAG_W    = 31;
    localparam int SQ_STEPS = 32;
    localparam int SUM_W    = 64;
    localparam int PROJ_W   = 36;

    function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [RND_W-1:0] v,
                                                          input int unsigned s);
        logic [RND_W-1:0] m;
        logic [RND_W-1:0] r;
        m = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        r = (m + (RND_W'(1) << (s - 1))) >> s;
        return v[RND_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
        if (v > 80'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -80'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [RND_W-1:0] v);
        if (v > 80'sd131071) begin
            return 18'sh1ffff;
        end else if (v < -80'sd131072) begin
            return 18'sh20000;
        end
        return 18'(v);
    endfunction

endpackage

FILE: rtl/lav_norm.sv
module lav_norm
    import lav_pkg::*;
#(
    parameter int IN_W      = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 192
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [IN_W-1:0]      in_c [3],
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+2:0] out_c [3],
    output logic [SIDE_W-1:0]           out_side
);

    localparam int QW   = FRAC_BITS + 2;
    localparam int LZW  = $clog2(IN_W + 1);
    localparam int NUMW = MAG_W + FRAC_BITS + 1;

    logic              a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic [IN_W-1:0]   a_mag_reg [3];
    logic [IN_W-1:0]   b_mag_reg [3];
    logic [IN_W-1:0]   c_mag_reg [3];
    logic [IN_W-1:0]   b_max_reg;
    logic [IN_W-1:0]   max_c;
    logic [LZW-1:0]    c_pos_reg;
    logic [LZW-1:0]    pos_c;
    logic              c_zero_reg, d_zero_reg, e_zero_reg;
    logic [2:0]        a_neg_reg, b_neg_reg, c_neg_reg, d_neg_reg, e_neg_reg;
    logic [SIDE_W-1:0] a_side_reg, b_side_reg, c_side_reg, d_side_reg, e_side_reg;
    logic [MAG_W-1:0]  d_m_reg [3];
    logic [MAG_W-1:0]  e_m_reg [3];
    logic [61:0]       e_sq_reg [3];

    logic [SUM_W-1:0]  sqv_reg [SQ_STEPS+1];
    logic [SUM_W-1:0]  sqr_reg [SQ_STEPS+1];
    logic [MAG_W-1:0]  sqm_reg [SQ_STEPS+1][3];
    logic [2:0]        sq_neg_reg [SQ_STEPS+1];
    logic              sq_zero_reg [SQ_STEPS+1];
    logic [SIDE_W-1:0] sq_side_reg [SQ_STEPS+1];
    logic              sq_valid_reg [SQ_STEPS+1];

    logic [31:0]       dv_rem_reg [QW+1][3];
    logic [QW-1:0]     dv_low_reg [QW+1][3];
    logic [QW-1:0]     dv_q_reg [QW+1][3];
    logic [31:0]       dv_len_reg [QW+1];
    logic [2:0]        dv_neg_reg [QW+1];
    logic              dv_zero_reg [QW+1];
    logic [SIDE_W-1:0] dv_side_reg [QW+1];
    logic              dv_valid_reg [QW+1];

    logic                        o_valid_reg;
    logic signed [FRAC_BITS+2:0] o_c_reg [3];
    logic [SIDE_W-1:0]           o_side_reg;

    always_comb begin
        max_c = a_mag_reg[0];
        if (a_mag_reg[1] > max_c) begin
            max_c = a_mag_reg[1];
        end
        if (a_mag_reg[2] > max_c) begin
            max_c = a_mag_reg[2];
        end
    end

    always_comb begin
        pos_c = '0;
        for (int j = 0; j < IN_W; j++) begin
            if (b_max_reg[j]) begin
                pos_c = LZW'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            d_valid_reg     <= 1'b0;
            e_valid_reg     <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end else if (en) begin
            a_valid_reg     <= in_valid;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            d_valid_reg     <= c_valid_reg;
            e_valid_reg     <= d_valid_reg;
            sq_valid_reg[0] <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_mag_reg[i] <= in_c[i][IN_W-1] ? IN_W'(-in_c[i]) : IN_W'(in_c[i]);
                a_neg_reg[i] <= in_c[i][IN_W-1];
                b_mag_reg[i] <= a_mag_reg[i];
                c_mag_reg[i] <= b_mag_reg[i];
                if (c_pos_reg >= LZW'(NORM_MSB)) begin
                    d_m_reg[i] <= MAG_W'(c_mag_reg[i] >> (c_pos_reg - LZW'(NORM_MSB)));
                end else begin
                    d_m_reg[i] <= MAG_W'(c_mag_reg[i]) << (LZW'(NORM_MSB) - c_pos_reg);
                end
                e_m_reg[i]  <= d_m_reg[i];
                e_sq_reg[i] <= 62'(d_m_reg[i]) * 62'(d_m_reg[i]);
                sqm_reg[0][i] <= e_m_reg[i];
            end
            a_side_reg     <= in_side;
            b_neg_reg      <= a_neg_reg;
            b_side_reg     <= a_side_reg;
            b_max_reg      <= max_c;
            c_neg_reg      <= b_neg_reg;
            c_side_reg     <= b_side_reg;
            c_pos_reg      <= pos_c;
            c_zero_reg     <= (b_max_reg == '0);
            d_neg_reg      <= c_neg_reg;
            d_side_reg     <= c_side_reg;
            d_zero_reg     <= c_zero_reg;
            e_neg_reg      <= d_neg_reg;
            e_side_reg     <= d_side_reg;
            e_zero_reg     <= d_zero_reg;
            sqv_reg[0]     <= SUM_W'(e_sq_reg[0]) + SUM_W'(e_sq_reg[1]) + SUM_W'(e_sq_reg[2]);
            sqr_reg[0]     <= '0;
            sq_neg_reg[0]  <= e_neg_reg;
            sq_zero_reg[0] <= e_zero_reg;
            sq_side_reg[0] <= e_side_reg;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [SUM_W-1:0] bitv;
        logic [SUM_W-1:0] trial;
        logic             ge;
        assign bitv  = SUM_W'(1) << (62 - 2 * k);
        assign trial = sqr_reg[k] + bitv;
        assign ge    = sqv_reg[k] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sqv_reg[k+1]     <= ge ? sqv_reg[k] - trial : sqv_reg[k];
                sqr_reg[k+1]     <= ge ? (sqr_reg[k] >> 1) + bitv : sqr_reg[k] >> 1;
                sqm_reg[k+1]     <= sqm_reg[k];
                sq_neg_reg[k+1]  <= sq_neg_reg[k];
                sq_zero_reg[k+1] <= sq_zero_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= 32'((NUMW'({sqm_reg[SQ_STEPS][i], {FRAC_BITS{1'b0}}})
                                   + NUMW'(sqr_reg[SQ_STEPS][31:1])) >> QW);
                dv_low_reg[0][i] <= QW'(NUMW'({sqm_reg[SQ_STEPS][i], {FRAC_BITS{1'b0}}})
                                   + NUMW'(sqr_reg[SQ_STEPS][31:1]));
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0]  <= sqr_reg[SQ_STEPS][31:0];
            dv_neg_reg[0]  <= sq_neg_reg[SQ_STEPS];
            dv_zero_reg[0] <= sq_zero_reg[SQ_STEPS];
            dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [32:0] trial;
            logic        ge;
            assign trial = {dv_rem_reg[k][i], dv_low_reg[k][i][QW-1]};
            assign ge    = trial >= {1'b0, dv_len_reg[k]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_rem_reg[k+1][i] <= ge ? 32'(trial - {1'b0, dv_len_reg[k]}) : trial[31:0];
                    dv_low_reg[k+1][i] <= dv_low_reg[k][i] << 1;
                    dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][QW-2:0], ge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_neg_reg[k+1]  <= dv_neg_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_zero_reg[QW]) begin
                    o_c_reg[i] <= '0;
                end else if (dv_neg_reg[QW][i]) begin
                    o_c_reg[i] <= -$signed({1'b0, dv_q_reg[QW][i]});
                end else begin
                    o_c_reg[i] <= $signed({1'b0, dv_q_reg[QW][i]});
                end
            end
            o_side_reg <= dv_side_reg[QW];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_c     = o_c_reg;
    assign out_side  = o_side_reg;

endmodule

FILE: rtl/look_at_view_matrix.sv
// Look-at view matrix unit. Each word on the slave channel carries a camera
// position, a target point and an up hint as nine signed fixed-point values.
// Each word on the master channel carries the nine basis components of the
// view matrix (right, up and forward axes, 18 bits each) and the three
// saturated translation entries (32 bits each).
// The unit is a single pipeline that takes one word per cycle. Two normalizer
// sections each hold a 32-step square root and a (FRAC_BITS + 2)-step divider.
// Throughput is one word per cycle while the master side accepts.
// The whole pipeline advances together: when the last stage holds a word
// that the receiver does not take, every stage holds and s_tready drops, so
// no word is lost or repeated. Bubbles stay in place while stalled.
// Reset clears every valid bit; data registers are not reset. There is no
// state carried from one word to the next.
module look_at_view_matrix
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // right_x..z, upaxis_x..z, fwd_x..z (18 bits each), shift_right, shift_up,
    // shift_fwd (32 bits each), then zero padding.
    output logic [263:0] m_tdata
);

    localparam int FW  = FRAC_BITS + 3;
    localparam int RW  = FW + 1;
    localparam int S1W = 192;
    localparam int S2W = 96 + 3 * FW;

    logic en;

    logic t0_valid_reg, t1_valid_reg, t2_valid_reg, t3_valid_reg, t4_valid_reg;
    logic t5_valid_reg, t6_valid_reg, t7_valid_reg, t8_valid_reg, t9_valid_reg;
    logic t10_valid_reg, t11_valid_reg, t12_valid_reg;

    logic signed [31:0] t0_pos_reg [3];
    logic signed [31:0] t0_up_reg [3];
    logic signed [32:0] t0_d_reg [3];
    logic [S1W-1:0]     t0_side;

    logic               n1_valid;
    logic signed [FW-1:0] n1_f [3];
    logic [S1W-1:0]     n1_side;
    logic signed [31:0] n1_pos [3];
    logic signed [31:0] n1_up [3];

    logic signed [31:0]      t1_pos_reg [3], t2_pos_reg [3], t3_pos_reg [3];
    logic signed [31:0]      t4_pos_reg [3], t5_pos_reg [3], t6_pos_reg [3];
    logic signed [31:0]      t1_up_reg [3], t2_up_reg [3], t3_up_reg [3];
    logic signed [31:0]      t4_up_reg [3], t5_up_reg [3];
    logic signed [FW-1:0]    t1_f_reg [3], t2_f_reg [3], t3_f_reg [3];
    logic signed [FW-1:0]    t4_f_reg [3], t5_f_reg [3], t6_f_reg [3];
    logic signed [FW+31:0]   t1_uf_reg [3];
    logic signed [FW+33:0]   t2_dot_reg;
    logic signed [PROJ_W-1:0] t3_p_reg;
    logic signed [FW+PROJ_W-1:0] t4_fp_reg [3];
    logic signed [PROJ_W-1:0] t5_a_reg [3];
    logic signed [PROJ_W-1:0] t6_n_reg [3];
    logic [S2W-1:0]          t6_side;

    logic                 n2_valid;
    logic signed [FW-1:0] n2_u [3];
    logic [S2W-1:0]       n2_side;
    logic signed [31:0]   n2_pos [3];
    logic signed [FW-1:0] n2_f [3];

    logic signed [31:0]     t7_pos_reg [3], t8_pos_reg [3], t9_pos_reg [3];
    logic signed [FW-1:0]   t7_u_reg [3], t8_u_reg [3], t9_u_reg [3], t10_u_reg [3], t11_u_reg [3];
    logic signed [FW-1:0]   t7_f_reg [3], t8_f_reg [3], t9_f_reg [3], t10_f_reg [3], t11_f_reg [3];
    logic signed [2*FW-1:0] t7_x_reg [6];
    logic signed [FW+31:0]  t7_pu_reg [3];
    logic signed [FW+31:0]  t7_pf_reg [3];
    logic signed [2*FW:0]   t8_cr_reg [3];
    logic signed [FW+33:0]  t8_su_reg, t8_sf_reg;
    logic signed [RW-1:0]   t9_r_reg [3], t10_r_reg [3], t11_r_reg [3];
    logic signed [31:0]     t9_tu_reg, t9_tf_reg, t10_tu_reg, t10_tf_reg, t11_tu_reg, t11_tf_reg;
    logic signed [RW+31:0]  t10_pr_reg [3];
    logic signed [RW+33:0]  t11_sr_reg;

    logic signed [17:0] t12_r_reg [3];
    logic signed [17:0] t12_u_reg [3];
    logic signed [17:0] t12_f_reg [3];
    logic signed [31:0] t12_tr_reg, t12_tu_reg, t12_tf_reg;

    assign en       = !t12_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = t12_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_valid_reg  <= 1'b0;
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            t3_valid_reg  <= 1'b0;
            t4_valid_reg  <= 1'b0;
            t5_valid_reg  <= 1'b0;
            t6_valid_reg  <= 1'b0;
            t7_valid_reg  <= 1'b0;
            t8_valid_reg  <= 1'b0;
            t9_valid_reg  <= 1'b0;
            t10_valid_reg <= 1'b0;
            t11_valid_reg <= 1'b0;
            t12_valid_reg <= 1'b0;
        end else if (en) begin
            t0_valid_reg  <= s_tvalid;
            t1_valid_reg  <= n1_valid;
            t2_valid_reg  <= t1_valid_reg;
            t3_valid_reg  <= t2_valid_reg;
            t4_valid_reg  <= t3_valid_reg;
            t5_valid_reg  <= t4_valid_reg;
            t6_valid_reg  <= t5_valid_reg;
            t7_valid_reg  <= n2_valid;
            t8_valid_reg  <= t7_valid_reg;
            t9_valid_reg  <= t8_valid_reg;
            t10_valid_reg <= t9_valid_reg;
            t11_valid_reg <= t10_valid_reg;
            t12_valid_reg <= t11_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t0_pos_reg[i] <= $signed(s_tdata[32*i +: 32]);
                t0_up_reg[i]  <= $signed(s_tdata[192+32*i +: 32]);
                t0_d_reg[i]   <= 33'($signed(s_tdata[96+32*i +: 32]))
                                 - 33'($signed(s_tdata[32*i +: 32]));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t0_side[32*i +: 32]    = t0_pos_reg[i];
            t0_side[96+32*i +: 32] = t0_up_reg[i];
            n1_pos[i] = $signed(n1_side[32*i +: 32]);
            n1_up[i]  = $signed(n1_side[96+32*i +: 32]);
            t6_side[32*i +: 32]    = t6_pos_reg[i];
            t6_side[96+FW*i +: FW] = t6_f_reg[i];
            n2_pos[i] = $signed(n2_side[32*i +: 32]);
            n2_f[i]   = $signed(n2_side[96+FW*i +: FW]);
        end
    end

    lav_norm #(
        .IN_W     (33),
        .FRAC_BITS(FRAC_BITS),
        .SIDE_W   (S1W)
    ) u_norm_fwd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (t0_valid_reg),
        .in_c     (t0_d_reg),
        .in_side  (t0_side),
        .out_valid(n1_valid),
        .out_c    (n1_f),
        .out_side (n1_side)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t1_uf_reg[i]  <= n1_up[i] * n1_f[i];
                t1_pos_reg[i] <= n1_pos[i];
                t1_up_reg[i]  <= n1_up[i];
                t1_f_reg[i]   <= n1_f[i];
                t2_pos_reg[i] <= t1_pos_reg[i];
                t2_up_reg[i]  <= t1_up_reg[i];
                t2_f_reg[i]   <= t1_f_reg[i];
                t3_pos_reg[i] <= t2_pos_reg[i];
                t3_up_reg[i]  <= t2_up_reg[i];
                t3_f_reg[i]   <= t2_f_reg[i];
                t4_fp_reg[i]  <= t3_f_reg[i] * t3_p_reg;
                t4_pos_reg[i] <= t3_pos_reg[i];
                t4_up_reg[i]  <= t3_up_reg[i];
                t4_f_reg[i]   <= t3_f_reg[i];
                t5_a_reg[i]   <= PROJ_W'(rnd_shift(t4_fp_reg[i], FRAC_BITS));
                t5_pos_reg[i] <= t4_pos_reg[i];
                t5_up_reg[i]  <= t4_up_reg[i];
                t5_f_reg[i]   <= t4_f_reg[i];
                t6_n_reg[i]   <= PROJ_W'(t5_up_reg[i]) - t5_a_reg[i];
                t6_pos_reg[i] <= t5_pos_reg[i];
                t6_f_reg[i]   <= t5_f_reg[i];
            end
            t2_dot_reg <= t1_uf_reg[0] + t1_uf_reg[1] + t1_uf_reg[2];
            t3_p_reg   <= PROJ_W'(rnd_shift(t2_dot_reg, FRAC_BITS));
        end
    end

    lav_norm #(
        .IN_W     (PROJ_W),
        .FRAC_BITS(FRAC_BITS),
        .SIDE_W   (S2W)
    ) u_norm_up (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (t6_valid_reg),
        .in_c     (t6_n_reg),
        .in_side  (t6_side),
        .out_valid(n2_valid),
        .out_c    (n2_u),
        .out_side (n2_side)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            t7_x_reg[0] <= n2_u[1] * n2_f[2];
            t7_x_reg[1] <= n2_u[2] * n2_f[1];
            t7_x_reg[2] <= n2_u[2] * n2_f[0];
            t7_x_reg[3] <= n2_u[0] * n2_f[2];
            t7_x_reg[4] <= n2_u[0] * n2_f[1];
            t7_x_reg[5] <= n2_u[1] * n2_f[0];
            for (int i = 0; i < 3; i++) begin
                t7_pu_reg[i]  <= n2_pos[i] * n2_u[i];
                t7_pf_reg[i]  <= n2_pos[i] * n2_f[i];
                t7_pos_reg[i] <= n2_pos[i];
                t7_u_reg[i]   <= n2_u[i];
                t7_f_reg[i]   <= n2_f[i];
                t8_cr_reg[i]  <= t7_x_reg[2*i] - t7_x_reg[2*i+1];
                t8_pos_reg[i] <= t7_pos_reg[i];
                t8_u_reg[i]   <= t7_u_reg[i];
                t8_f_reg[i]   <= t7_f_reg[i];
                t9_r_reg[i]   <= RW'(rnd_shift(t8_cr_reg[i], FRAC_BITS));
                t9_pos_reg[i] <= t8_pos_reg[i];
                t9_u_reg[i]   <= t8_u_reg[i];
                t9_f_reg[i]   <= t8_f_reg[i];
                t10_pr_reg[i] <= t9_pos_reg[i] * t9_r_reg[i];
                t10_r_reg[i]  <= t9_r_reg[i];
                t10_u_reg[i]  <= t9_u_reg[i];
                t10_f_reg[i]  <= t9_f_reg[i];
                t11_r_reg[i]  <= t10_r_reg[i];
                t11_u_reg[i]  <= t10_u_reg[i];
                t11_f_reg[i]  <= t10_f_reg[i];
                t12_r_reg[i]  <= sat18(t11_r_reg[i]);
                t12_u_reg[i]  <= sat18(t11_u_reg[i]);
                t12_f_reg[i]  <= sat18(t11_f_reg[i]);
            end
            t8_su_reg  <= t7_pu_reg[0] + t7_pu_reg[1] + t7_pu_reg[2];
            t8_sf_reg  <= t7_pf_reg[0] + t7_pf_reg[1] + t7_pf_reg[2];
            t9_tu_reg  <= sat32(-rnd_shift(t8_su_reg, FRAC_BITS));
            t9_tf_reg  <= sat32(-rnd_shift(t8_sf_reg, FRAC_BITS));
            t10_tu_reg <= t9_tu_reg;
            t10_tf_reg <= t9_tf_reg;
            t11_sr_reg <= t10_pr_reg[0] + t10_pr_reg[1] + t10_pr_reg[2];
            t11_tu_reg <= t10_tu_reg;
            t11_tf_reg <= t10_tf_reg;
            t12_tr_reg <= sat32(-rnd_shift(t11_sr_reg, FRAC_BITS));
            t12_tu_reg <= t11_tu_reg;
            t12_tf_reg <= t11_tf_reg;
        end
    end

    assign m_tdata = {6'b0, t12_tf_reg, t12_tu_reg, t12_tr_reg,
                      t12_f_reg[2], t12_f_reg[1], t12_f_reg[0],
                      t12_u_reg[2], t12_u_reg[1], t12_u_reg[0],
                      t12_r_reg[2], t12_r_reg[1], t12_r_reg[0]};

    // A zero forward or up axis leaves nothing for the cross product.
    a_fwd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && t12_f_reg[0] == '0 && t12_f_reg[1] == '0 && t12_f_reg[2] == '0)
        |-> (t12_r_reg[0] == '0 && t12_r_reg[1] == '0 && t12_r_reg[2] == '0))
        else $error("right axis nonzero with zero forward axis");

    a_up_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && t12_u_reg[0] == '0 && t12_u_reg[1] == '0 && t12_u_reg[2] == '0)
        |-> (t12_r_reg[0] == '0 && t12_r_reg[1] == '0 && t12_r_reg[2] == '0))
        else $error("right axis nonzero with zero up axis");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && t11_valid_reg) |=> m_tvalid)
        else $error("word dropped at the output stage");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(t12_tr_reg) && $stable(t12_tu_reg) && $stable(t12_tf_reg)))
        else $error("output word changed while stalled");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int FB = 16;
    localparam int LATENCY = 2 * FB + 97;
    localparam int RANDOM_WORDS = 700;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] shift_fwd;
        logic signed [31:0] shift_up;
        logic signed [31:0] shift_right;
        logic signed [17:0] fwd_z;
        logic signed [17:0] fwd_y;
        logic signed [17:0] fwd_x;
        logic signed [17:0] upaxis_z;
        logic signed [17:0] upaxis_y;
        logic signed [17:0] upaxis_x;
        logic signed [17:0] right_z;
        logic signed [17:0] right_y;
        logic signed [17:0] right_x;
    } view_t;

    typedef struct {
        logic [287:0] word;
        bit           typed;
        view_t        view;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [263:0] m_tdata;

    view_t  expected_views[$];
    row_t   rows[$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     hold_receiver = 1'b0;

    look_at_view_matrix #(.FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (mag(v) + (64'sd1 <<< (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void unit_vector(input longint c[3], output longint o[3]);
        longint unsigned m[3], mx, sum, len, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(c[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            o = '{0, 0, 0};
            return;
        end
        while (mx >= (64'd1 << 31)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic view_t predict_view(logic [287:0] w);
        longint pos[3], up[3], d[3], f[3], n[3], u[3], r[3], ax[3][3];
        longint dot, p, s;
        logic [17:0] axis[9];
        logic [31:0] shift[3];
        view_t v;
        for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(w[32*i +: 32]));
            d[i] = longint'($signed(w[32*(3+i) +: 32])) - pos[i];
            up[i] = longint'($signed(w[32*(6+i) +: 32]));
        end
        unit_vector(d, f);
        dot = 0;
        for (int i = 0; i < 3; i++) dot += up[i] * f[i];
        p = round_shift(dot, FB);
        for (int i = 0; i < 3; i++) n[i] = up[i] - round_shift(f[i] * p, FB);
        unit_vector(n, u);
        r[0] = round_shift(u[1] * f[2] - u[2] * f[1], FB);
        r[1] = round_shift(u[2] * f[0] - u[0] * f[2], FB);
        r[2] = round_shift(u[0] * f[1] - u[1] * f[0], FB);
        ax[0] = r;
        ax[1] = u;
        ax[2] = f;
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int j = 0; j < 3; j++) begin
                axis[3*i+j] = 18'(clamp(ax[i][j], -(64'sd1 <<< 17), (64'sd1 <<< 17) - 1));
                s += pos[j] * ax[i][j];
            end
            shift[i] = 32'(clamp(-round_shift(s, FB), -64'sd2147483648, 64'sd2147483647));
        end
        v.right_x = axis[0];  v.right_y = axis[1];  v.right_z = axis[2];
        v.upaxis_x = axis[3]; v.upaxis_y = axis[4]; v.upaxis_z = axis[5];
        v.fwd_x = axis[6];    v.fwd_y = axis[7];    v.fwd_z = axis[8];
        v.shift_right = shift[0];
        v.shift_up = shift[1];
        v.shift_fwd = shift[2];
        return v;
    endfunction

    function automatic logic [287:0] pack_camera(int px, int py, int pz, int tx, int ty,
                                                 int tz, int ux, int uy, int uz);
        return {uz, uy, ux, tz, ty, tx, pz, py, px};
    endfunction

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return int'($urandom_range(0, 8 << FB)) - (4 << FB);
            2: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom_range(0, 7) - 4;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic send_word(logic [287:0] w, bit typed, view_t v);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        expected_views = {expected_views, typed ? v : predict_view(w)};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic add_row(logic [287:0] w, bit typed = 0, view_t v = '0);
        row_t r;
        r.word = w;
        r.typed = typed;
        r.view = v;
        rows = {rows, r};
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_receiver) begin
            m_tready <= 1'b1;
        end else if ((cycle_count / 300) % 3 == 2) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 9) < 6);
        end
    end

    always @(posedge aclk) begin
        view_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = view_t'(m_tdata[257:0]);
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
            end else begin
                want = expected_views.pop_front();
                if (got.right_x !== want.right_x)
                    report_mismatch("right_x", 32'(got.right_x), 32'(want.right_x));
                if (got.right_y !== want.right_y)
                    report_mismatch("right_y", 32'(got.right_y), 32'(want.right_y));
                if (got.right_z !== want.right_z)
                    report_mismatch("right_z", 32'(got.right_z), 32'(want.right_z));
                if (got.upaxis_x !== want.upaxis_x)
                    report_mismatch("upaxis_x", 32'(got.upaxis_x), 32'(want.upaxis_x));
                if (got.upaxis_y !== want.upaxis_y)
                    report_mismatch("upaxis_y", 32'(got.upaxis_y), 32'(want.upaxis_y));
                if (got.upaxis_z !== want.upaxis_z)
                    report_mismatch("upaxis_z", 32'(got.upaxis_z), 32'(want.upaxis_z));
                if (got.fwd_x !== want.fwd_x)
                    report_mismatch("fwd_x", 32'(got.fwd_x), 32'(want.fwd_x));
                if (got.fwd_y !== want.fwd_y)
                    report_mismatch("fwd_y", 32'(got.fwd_y), 32'(want.fwd_y));
                if (got.fwd_z !== want.fwd_z)
                    report_mismatch("fwd_z", 32'(got.fwd_z), 32'(want.fwd_z));
                if (got.shift_right !== want.shift_right)
                    report_mismatch("shift_right", got.shift_right, want.shift_right);
                if (got.shift_up !== want.shift_up)
                    report_mismatch("shift_up", got.shift_up, want.shift_up);
                if (got.shift_fwd !== want.shift_fwd)
                    report_mismatch("shift_fwd", got.shift_fwd, want.shift_fwd);
            end
        end
    end

    initial begin
        view_t v;
        int one, mode, burst;
        logic [287:0] w;
        one = 1 << FB;

        // All-zero input: every field of the view is zero.
        add_row('0, 1, '0);
        // Forward along +z with up along +y at the origin.
        v = '0;
        v.right_x = 18'(one);
        v.upaxis_y = 18'(one);
        v.fwd_z = 18'(one);
        add_row(pack_camera(0, 0, 0, 0, 0, one, 0, one, 0), 1, v);
        // Target equal to position, up hint alone.
        add_row(pack_camera(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, 0, 5));
        // Up hint parallel to forward, and a zero up hint.
        add_row(pack_camera(0, 0, 0, 0, 0, one, 0, 0, 3 * one));
        add_row(pack_camera(one, 0, 0, 7 * one, 0, 0, 0, 0, 0));
        // Extremes of every field.
        add_row({9{32'h7fffffff}});
        add_row({9{32'h80000000}});
        add_row({{3{32'h7fffffff}}, {3{32'h80000000}}, {3{32'h7fffffff}}});
        add_row({{3{32'h80000000}}, {3{32'h7fffffff}}, {3{32'h80000000}}});
        add_row(pack_camera(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            32'h80000000, 32'h7fffffff, 1, -1, 1));
        add_row(pack_camera(-1, -1, -1, 1, 1, 1, -1, 1, -1));
        add_row({9{32'hffffffff}});
        // Saturating translation: far position with axes that grow it.
        add_row(pack_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                            32'h80000000, 32'h80000000, 0, one, 0));
        add_row(pack_camera(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, one, 0, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].view);

        for (int n = 0; n < RANDOM_WORDS; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RANDOM_WORDS; b++, n++) begin
                if (n == RANDOM_WORDS / 2) begin
                    s_tvalid <= 1'b0;
                    do @(posedge aclk); while (expected_views.size() != 0);
                end
                mode = $urandom_range(0, 3);
                w = pack_camera(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                                rand_coord(mode), rand_coord(mode), rand_coord(mode),
                                rand_coord(mode), rand_coord(mode), rand_coord(mode));
                if ($urandom_range(0, 15) == 0) w[95:0] = w[191:96];
                if ($urandom_range(0, 15) == 0) w[287:192] = w[191:96];
                send_word(w, 0, '0);
            end
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end

        hold_receiver = 1'b1;
        while (expected_views.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
